@@ hdl/rtp_jitter_reorder_buffer_defines.svh @@
// ---------------------------------------------------------------------------
// RTP jitter reorder buffer - assertion macros
// Immediate-implication and next-cycle-implication checks, gated by reset.
// ---------------------------------------------------------------------------
`ifndef RTP_JITTER_REORDER_BUFFER_DEFINES_SVH
`define RTP_JITTER_REORDER_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

`define RJB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rtp jitter reorder buffer: check failed");

`define RJB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rtp jitter reorder buffer: check failed");

`else

`define RJB_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define RJB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/rtp_jrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// RTP jitter reorder buffer - package
// Beat types, result codes, sequencer states and shared constants.
// ---------------------------------------------------------------------------
package rtp_jrb_pkg;

  localparam int unsigned SEQ_W         = 48;
  localparam int unsigned TS_W          = 32;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned RTP_SEQ_W     = 16;
  localparam int unsigned WRAP_W        = 32;
  localparam int unsigned LIMIT_W       = 6;
  localparam int unsigned DEFAULT_DEPTH = 32;
  localparam int unsigned LIMIT_RESET   = 32;
  localparam int unsigned WRAP_LOW      = 536;
  localparam int unsigned WRAP_HIGH     = 65000;

  localparam logic [2:0] KIND_READY     = 3'd0;
  localparam logic [2:0] KIND_ERASURE   = 3'd1;
  localparam logic [2:0] KIND_LATE      = 3'd2;
  localparam logic [2:0] KIND_DUPLICATE = 3'd3;
  localparam logic [2:0] KIND_BAD_HDR   = 3'd4;
  localparam logic [2:0] KIND_FLUSHED   = 3'd5;

  localparam logic REG_BUFFER_LIMIT = 1'b0;

  typedef struct packed {
    logic                 command;
    logic [RTP_SEQ_W-1:0] seq_number;
    logic [TS_W-1:0]      timestamp;
    logic [TAG_W-1:0]     packet_tag;
    logic                 header_bad;
  } in_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [TAG_W-1:0] out_tag;
    logic [SEQ_W-1:0] logical_seq;
    logic [TS_W-1:0]  out_timestamp;
    logic [SEQ_W-1:0] gap_start;
    logic [SEQ_W-1:0] gap_end;
    logic [TS_W-1:0]  gap_ts_step;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  ts;
    logic [TAG_W-1:0] tag;
  } held_t;

  typedef enum logic [1:0] {
    BUF_NOP,
    BUF_INS,
    BUF_POP
  } buf_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK,
    ST_WRAP,
    ST_LATE,
    ST_PLACE,
    ST_SRCH,
    ST_INS,
    ST_LIM,
    ST_RUN0,
    ST_RUN,
    ST_DROP,
    ST_REL,
    ST_ERA_A,
    ST_ERA_B,
    ST_DIVGO,
    ST_DIV,
    ST_ERA_OUT,
    ST_OUT,
    ST_REMOVE
  } state_e;

endpackage
`default_nettype wire

@@ hdl/rtp_jrb_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// RTP jitter reorder buffer - held packet store
// Sorted entry array with insert-at-position, pop-front and one read port.
// ---------------------------------------------------------------------------
module rtp_jrb_buf #(
  parameter int unsigned DEPTH = rtp_jrb_pkg::DEFAULT_DEPTH,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire rtp_jrb_pkg::buf_op_e op_i,
  input  wire logic [IW-1:0]        pos_i,
  input  wire rtp_jrb_pkg::held_t   wr_i,
  input  wire logic [IW-1:0]        rd_idx_i,
  output rtp_jrb_pkg::held_t        rd_o
);
  import rtp_jrb_pkg::*;

  held_t mem_q [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    always_ff @(posedge clk_i) begin
      case (op_i)
        BUF_INS: begin
          if (IW'(g) == pos_i) begin
            mem_q[g] <= wr_i;
          end else if (IW'(g) > pos_i) begin
            mem_q[g] <= mem_q[(g > 0) ? g - 1 : 0];
          end
        end
        BUF_POP: begin
          // advance toward the head
          if (g < DEPTH - 1) begin
            mem_q[g] <= mem_q[(g < DEPTH - 1) ? g + 1 : g];
          end
        end
        default: ;
      endcase
    end
  end

  assign rd_o = mem_q[rd_idx_i];

endmodule
`default_nettype wire

@@ hdl/rtp_jrb_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// RTP jitter reorder buffer - serial divider
// Restoring division, one quotient bit per cycle; zero divisor gives all ones.
// ---------------------------------------------------------------------------
module rtp_jrb_div #(
  parameter int unsigned W = rtp_jrb_pkg::TS_W,
  localparam int unsigned CNTW = $clog2(W + 1)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              busy_o,
  output logic [W-1:0]      quotient_o
);
  import rtp_jrb_pkg::*;

  logic [W-1:0]    rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [W:0]      shifted, trial;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    trial   = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = CNTW'(W);
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

@@ hdl/rtp_jitter_reorder_buffer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// RTP jitter reorder buffer - top level
// Extends RTP sequence numbers, drops bad-header, late and duplicate packets,
// holds the rest sorted and releases consecutive runs with erasure beats for gaps.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o, in_data_i) carries one packet
//   header or a flush command per beat. Output channel (out_valid_o /
//   out_ready_i, out_data_o) carries zero to DEPTH+1 result beats per input;
//   the final one has last set. Inputs that only store a packet give none.
//   in_ready_o is high only while the sequencer is idle. A store-only insert
//   walks the sorted entries to find its position. A release scans the run,
//   emits each released beat and, unless flushing, then pops each one; an
//   erasure beat first waits for the serial 32-bit divider.
//   A single output register sits between the sequencer and the receiver, so
//   the next input is taken while the final beat still waits. When the
//   receiver stalls, the sequencer holds in its current emitting step.
//   Reset empties the buffer, clears sequence tracking and sets buffer_limit
//   to 32; no clearing pass is needed. buffer_limit sits at APB address 0
//   and must be written only while idle; the block does not enforce this.
// ---------------------------------------------------------------------------
`include "rtp_jitter_reorder_buffer_defines.svh"

module rtp_jitter_reorder_buffer #(
  parameter int unsigned DEPTH = rtp_jrb_pkg::DEFAULT_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rtp_jrb_pkg::in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rtp_jrb_pkg::out_t       out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import rtp_jrb_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = 7;

  state_e state_q, state_d;

  // configuration
  logic [LIMIT_W-1:0] limit_q;
  logic [LW-1:0]      lim_eff;

  // tracking state
  in_t              in_q;
  logic [SEQ_W-1:0] lseq_q, last_seq_q, max_seq_q, tmp_q, prev_q, gs_q, ge_q;
  logic [SEQ_W-1:0] dtmp_q;
  logic [WRAP_W-1:0] wrap_q;
  logic [TS_W-1:0]  last_ts_q, tsd_q, cnt32_q, prod_q;
  logic             rel_valid_q, maxv_q, gt65_q, flush_q;
  logic [CW-1:0]    count_q, idx_q, pos_q, start_q, end_q, rem_q;

  // output register
  out_t out_q;
  logic out_vq;

  // sequencer outputs
  logic        emit_en, emit_fire, slot_free;
  out_t        emit_d;
  logic [SEQ_W-1:0] alu_a, alu_b, alu_diff;
  logic        alu_brw, alu_lt, alu_eq, alu_one;
  logic [IW-1:0] rd_idx, buf_pos;
  buf_op_e     buf_op;
  held_t       rd_ent, wr_ent;
  logic        div_start, div_busy;
  logic [TS_W-1:0] div_quot;

  logic prewrap, place_rel, place_now, run_last;

  // shared subtract / compare unit
  assign {alu_brw, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_lt  = alu_brw;
  assign alu_eq  = (alu_diff == '0);
  assign alu_one = (alu_diff == SEQ_W'(1));

  assign lim_eff   = (LW'(limit_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(limit_q);
  assign prewrap   = (max_seq_q[15:0] < 16'(WRAP_LOW)) &&
                     (in_q.seq_number > 16'(WRAP_HIGH));
  assign place_rel = (rel_valid_q && alu_one) || (!rel_valid_q && lseq_q == '0);
  assign place_now = !maxv_q || count_q == '0;
  assign run_last  = ((idx_q + CW'(1)) == end_q);
  assign slot_free = !out_vq || out_ready_i;
  assign emit_fire = emit_en && slot_free;
  assign wr_ent    = '{seq: lseq_q, ts: in_q.timestamp, tag: in_q.packet_tag};

  rtp_jrb_buf #(.DEPTH(DEPTH)) u_buf (
    .clk_i    (clk_i),
    .op_i     (buf_op),
    .pos_i    (buf_pos),
    .wr_i     (wr_ent),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_ent)
  );

  rtp_jrb_div #(.W(TS_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (cnt32_q + TS_W'(1)),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // sequencer outputs: operand selection, beat contents, store control
  always_comb begin
    in_ready_o = 1'b0;
    emit_en    = 1'b0;
    emit_d     = '0;
    alu_a      = lseq_q;
    alu_b      = last_seq_q;
    rd_idx     = idx_q[IW-1:0];
    buf_op     = BUF_NOP;
    buf_pos    = pos_q[IW-1:0];
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_CHK: begin
        alu_a = max_seq_q;
        alu_b = SEQ_W'(WRAP_HIGH);
        if (in_q.header_bad) begin
          emit_en        = 1'b1;
          emit_d.kind    = KIND_BAD_HDR;
          emit_d.out_tag = in_q.packet_tag;
          emit_d.last    = 1'b1;
        end else if (maxv_q && prewrap && wrap_q == '0) begin
          emit_en              = 1'b1;
          emit_d.kind          = KIND_LATE;
          emit_d.out_tag       = in_q.packet_tag;
          emit_d.logical_seq   = SEQ_W'(in_q.seq_number);
          emit_d.out_timestamp = in_q.timestamp;
          emit_d.last          = 1'b1;
        end
      end
      ST_WRAP: begin
        alu_a = lseq_q;
        alu_b = tmp_q;
      end
      ST_LATE: begin
        if (rel_valid_q && (alu_eq || alu_lt)) begin
          emit_en              = 1'b1;
          emit_d.kind          = alu_eq ? KIND_DUPLICATE : KIND_LATE;
          emit_d.out_tag       = in_q.packet_tag;
          emit_d.logical_seq   = lseq_q;
          emit_d.out_timestamp = in_q.timestamp;
          emit_d.last          = 1'b1;
        end
      end
      ST_PLACE: begin
        if (place_now && place_rel) begin
          emit_en              = 1'b1;
          emit_d.kind          = KIND_READY;
          emit_d.out_tag       = in_q.packet_tag;
          emit_d.logical_seq   = lseq_q;
          emit_d.out_timestamp = in_q.timestamp;
          emit_d.last          = 1'b1;
        end else if (place_now) begin
          buf_op  = BUF_INS;
          buf_pos = '0;
        end
      end
      ST_SRCH: begin
        alu_a = rd_ent.seq;
        alu_b = lseq_q;
        if (alu_eq) begin
          emit_en              = 1'b1;
          emit_d.kind          = KIND_DUPLICATE;
          emit_d.out_tag       = in_q.packet_tag;
          emit_d.logical_seq   = lseq_q;
          emit_d.out_timestamp = in_q.timestamp;
          emit_d.last          = 1'b1;
        end
      end
      ST_INS: buf_op = BUF_INS;
      ST_LIM: begin
        rd_idx = '0;
        alu_a  = rd_ent.seq;
      end
      ST_RUN0: rd_idx = '0;
      ST_RUN: begin
        alu_a = rd_ent.seq;
        alu_b = prev_q;
      end
      ST_DROP: begin
        emit_en              = 1'b1;
        emit_d.kind          = KIND_FLUSHED;
        emit_d.out_tag       = rd_ent.tag;
        emit_d.logical_seq   = rd_ent.seq;
        emit_d.out_timestamp = rd_ent.ts;
      end
      ST_REL: begin
        rd_idx = start_q[IW-1:0];
        alu_a  = rd_ent.seq;
      end
      ST_ERA_A: begin
        rd_idx = start_q[IW-1:0];
        alu_a  = last_seq_q;
        alu_b  = '1;
      end
      ST_ERA_B: begin
        rd_idx = start_q[IW-1:0];
        alu_a  = rd_ent.seq;
        alu_b  = SEQ_W'(1);
      end
      ST_DIVGO: div_start = 1'b1;
      ST_DIV: ;
      ST_ERA_OUT: begin
        emit_en            = 1'b1;
        emit_d.kind        = KIND_ERASURE;
        emit_d.gap_start   = gs_q;
        emit_d.gap_end     = ge_q;
        emit_d.gap_ts_step = div_quot;
      end
      ST_OUT: begin
        emit_en              = 1'b1;
        emit_d.kind          = KIND_READY;
        emit_d.out_tag       = rd_ent.tag;
        emit_d.logical_seq   = rd_ent.seq;
        emit_d.out_timestamp = rd_ent.ts;
        emit_d.last          = run_last;
      end
      ST_REMOVE: buf_op = BUF_POP;
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!in_data_i.command) begin
            state_d = ST_CHK;
          end else if (count_q != '0) begin
            state_d = ST_RUN0;
          end
        end
      end
      ST_CHK: begin
        if (emit_en) begin
          if (emit_fire) state_d = ST_IDLE;
        end else if (!maxv_q) begin
          state_d = ST_PLACE;
        end else if (prewrap) begin
          state_d = ST_LATE;
        end else begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: state_d = ST_LATE;
      ST_LATE: begin
        if (emit_en) begin
          if (emit_fire) state_d = ST_IDLE;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (emit_en) begin
          if (emit_fire) state_d = ST_IDLE;
        end else if (place_now) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (emit_en) begin
          if (emit_fire) state_d = ST_IDLE;
        end else if (!alu_lt || (idx_q + CW'(1)) == count_q) begin
          state_d = ST_INS;
        end
      end
      ST_INS: state_d = ST_LIM;
      ST_LIM: begin
        if (LW'(count_q) >= lim_eff || (rel_valid_q && alu_one)) begin
          state_d = ST_RUN0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN0: state_d = ST_RUN;
      ST_RUN: begin
        if (idx_q == count_q) begin
          state_d = (flush_q && start_q != '0) ? ST_DROP : ST_REL;
        end else if (!alu_one && !flush_q) begin
          state_d = ST_REL;
        end
      end
      ST_DROP: begin
        if (emit_fire && (idx_q + CW'(1)) == start_q) state_d = ST_REL;
      end
      ST_REL: state_d = (rel_valid_q && !alu_one) ? ST_ERA_A : ST_OUT;
      ST_ERA_A: state_d = ST_ERA_B;
      ST_ERA_B: state_d = ST_DIVGO;
      ST_DIVGO: state_d = ST_DIV;
      ST_DIV: if (!div_busy) state_d = ST_ERA_OUT;
      ST_ERA_OUT: if (emit_fire) state_d = ST_OUT;
      ST_OUT: begin
        if (emit_fire && run_last) state_d = flush_q ? ST_IDLE : ST_REMOVE;
      end
      ST_REMOVE: if (rem_q == CW'(1)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_W'(LIMIT_RESET);
      wrap_q      <= '0;
      last_seq_q  <= '0;
      last_ts_q   <= '0;
      max_seq_q   <= '0;
      rel_valid_q <= 1'b0;
      maxv_q      <= 1'b0;
      count_q     <= '0;
      out_vq      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && paddr[2] == REG_BUFFER_LIMIT) begin
        limit_q <= pwdata[LIMIT_W-1:0];
      end
      if (emit_fire) begin
        out_vq <= 1'b1;
      end else if (out_ready_i) begin
        out_vq <= 1'b0;
      end
      case (state_q)
        ST_WRAP: begin
          if (gt65_q && alu_lt) wrap_q <= wrap_q + WRAP_W'(1);
        end
        ST_PLACE: begin
          if (place_now && (!place_rel || emit_fire)) begin
            max_seq_q <= lseq_q;
            maxv_q    <= 1'b1;
            if (place_rel) begin
              last_seq_q  <= lseq_q;
              last_ts_q   <= in_q.timestamp;
              rel_valid_q <= 1'b1;
            end else begin
              count_q <= CW'(1);
            end
          end
        end
        ST_SRCH: begin
          if (!alu_eq && alu_lt && (idx_q + CW'(1)) == count_q) max_seq_q <= lseq_q;
        end
        ST_INS: count_q <= count_q + CW'(1);
        ST_OUT: begin
          if (emit_fire) begin
            last_seq_q  <= rd_ent.seq;
            last_ts_q   <= rd_ent.ts;
            rel_valid_q <= 1'b1;
            if (run_last && flush_q) count_q <= '0;
          end
        end
        ST_REMOVE: count_q <= count_q - CW'(1);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (emit_fire) out_q <= emit_d;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_q    <= in_data_i;
          lseq_q  <= {wrap_q, in_data_i.seq_number};
          flush_q <= in_data_i.command;
          idx_q   <= '0;
        end
      end
      ST_CHK: begin
        tmp_q  <= alu_diff;
        gt65_q <= !alu_lt && !alu_eq;
        if (maxv_q && prewrap) lseq_q <= {wrap_q - WRAP_W'(1), in_q.seq_number};
      end
      ST_WRAP: begin
        if (gt65_q && alu_lt) lseq_q <= {wrap_q + WRAP_W'(1), in_q.seq_number};
      end
      ST_SRCH: begin
        if (!alu_lt) begin
          pos_q <= idx_q;
        end else if ((idx_q + CW'(1)) == count_q) begin
          pos_q <= count_q;
        end else begin
          idx_q <= idx_q + CW'(1);
        end
      end
      ST_RUN0: begin
        prev_q  <= rd_ent.seq;
        idx_q   <= CW'(1);
        start_q <= '0;
      end
      ST_RUN: begin
        if (idx_q == count_q) begin
          end_q <= count_q;
          idx_q <= '0;
        end else if (alu_one) begin
          prev_q <= rd_ent.seq;
          idx_q  <= idx_q + CW'(1);
        end else if (flush_q) begin
          // a fresh run starts here; keep walking
          start_q <= idx_q;
          prev_q  <= rd_ent.seq;
          idx_q   <= idx_q + CW'(1);
        end else begin
          end_q <= idx_q;
        end
      end
      ST_DROP: if (emit_fire) idx_q <= idx_q + CW'(1);
      ST_REL: begin
        dtmp_q <= alu_diff;
        idx_q  <= start_q;
      end
      ST_ERA_A: begin
        gs_q    <= alu_diff;
        tsd_q   <= rd_ent.ts - last_ts_q;
        cnt32_q <= dtmp_q[TS_W-1:0] - TS_W'(1);
      end
      ST_ERA_B: begin
        ge_q   <= alu_diff;
        prod_q <= TS_W'(tsd_q * cnt32_q);
      end
      ST_OUT: begin
        if (emit_fire) begin
          idx_q <= idx_q + CW'(1);
          rem_q <= end_q;
        end
      end
      ST_REMOVE: rem_q <= rem_q - CW'(1);
      default: ;
    endcase
  end

  assign out_valid_o = out_vq;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_BUFFER_LIMIT) ? 32'(limit_q) : '0;

  `RJB_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(DEPTH))
  `RJB_ASSERT_NOW(a_ins_room, clk_i, rst_ni, state_q == ST_INS, count_q < CW'(DEPTH))
  `RJB_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, emit_fire && emit_d.last, state_q == ST_IDLE || state_q == ST_REMOVE)
  `RJB_ASSERT_NOW(a_div_done, clk_i, rst_ni, state_q == ST_ERA_OUT, !div_busy)

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RTP jitter reorder buffer - testbench
// Drives packet headers and flush commands with random gaps and receiver
// stalls, predicts every result beat in a local model of the buffer and
// compares each beat with the oldest prediction, across several limits.
// ---------------------------------------------------------------------------
module tb_top;
  import rtp_jrb_pkg::*;

  localparam int unsigned HOLD_DEPTH  = 32;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE      = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rtp_jitter_reorder_buffer dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the buffer state, kept in step with every accepted input beat.
  logic [SEQ_W-1:0]  hold_seq [HOLD_DEPTH];
  logic [TS_W-1:0]   hold_ts  [HOLD_DEPTH];
  logic [TAG_W-1:0]  hold_tag [HOLD_DEPTH];
  int unsigned       hold_cnt;
  logic [WRAP_W-1:0] wraps;
  logic [SEQ_W-1:0]  rel_seq;
  logic [TS_W-1:0]   rel_ts;
  logic [SEQ_W-1:0]  top_seq;
  logic              rel_ok;
  logic              top_ok;
  int unsigned       limit_reg;

  out_t pending_beats [$];
  out_t expected_beats [$];

  int unsigned fails, mismatches, items_sent, beats_seen, erasures_seen, cycles;
  bit          quiet;
  int unsigned stall_left;

  // Sequence generator for well-formed traffic.
  logic [15:0] gen_seq;
  logic [31:0] gen_ts;

  function automatic void add_beat(logic [2:0] kind, logic [TAG_W-1:0] tag,
                                   logic [SEQ_W-1:0] lseq, logic [TS_W-1:0] ts,
                                   logic [SEQ_W-1:0] gs, logic [SEQ_W-1:0] ge,
                                   logic [TS_W-1:0] step);
    out_t b;
    b = '{kind: kind, out_tag: tag, logical_seq: lseq, out_timestamp: ts,
          gap_start: gs, gap_end: ge, gap_ts_step: step, last: 1'b0};
    pending_beats.push_back(b);
  endfunction

  function automatic int unsigned run_stop(int unsigned i);
    int unsigned j;
    j = i + 1;
    while (j < hold_cnt && (hold_seq[j-1] + 48'd1) == hold_seq[j]) j++;
    return j;
  endfunction

  // Release entries i..j-1, preceded by an erasure when a gap is skipped.
  function automatic void release_run(int unsigned i, int unsigned j);
    logic [SEQ_W-1:0] diff;
    logic [31:0]      tsd, cnt, dvs, step;
    logic [63:0]      prod;
    if (rel_ok && (rel_seq + 48'd1) != hold_seq[i]) begin
      diff = hold_seq[i] - rel_seq - 48'd1;
      cnt  = diff[31:0];
      tsd  = hold_ts[i] - rel_ts;
      prod = tsd * cnt;
      dvs  = cnt + 32'd1;
      step = (dvs != 0) ? prod[31:0] / dvs : '1;
      add_beat(KIND_ERASURE, '0, '0, '0, rel_seq + 48'd1, hold_seq[i] - 48'd1, step);
    end
    for (int unsigned k = i; k < j; k++)
      add_beat(KIND_READY, hold_tag[k], hold_seq[k], hold_ts[k], '0, '0, '0);
    rel_seq = hold_seq[j-1];
    rel_ts  = hold_ts[j-1];
    rel_ok  = 1'b1;
  endfunction

  function automatic void predict_flush();
    int unsigned i, j;
    i = 0;
    if (hold_cnt == 0) return;
    forever begin
      j = run_stop(i);
      if (j >= hold_cnt) break;
      for (int unsigned k = i; k < j; k++)
        add_beat(KIND_FLUSHED, hold_tag[k], hold_seq[k], hold_ts[k], '0, '0, '0);
      i = j;
    end
    release_run(i, hold_cnt);
    hold_cnt = 0;
  endfunction

  function automatic void predict_packet(in_t it);
    logic [SEQ_W-1:0] lseq;
    int unsigned      pos, lim, j;
    lseq = {wraps, it.seq_number};
    if (top_ok) begin
      if (top_seq[15:0] < WRAP_LOW && it.seq_number > WRAP_HIGH) begin
        if (wraps == 0) begin
          add_beat(KIND_LATE, it.packet_tag, {32'd0, it.seq_number}, it.timestamp,
                   '0, '0, '0);
          return;
        end
        lseq = lseq - 48'h10000;
      end else if (top_seq > WRAP_HIGH && lseq < top_seq - WRAP_HIGH) begin
        wraps = wraps + 1;
        lseq  = lseq + 48'h10000;
      end
      if (rel_ok && lseq <= rel_seq) begin
        add_beat((lseq == rel_seq) ? KIND_DUPLICATE : KIND_LATE, it.packet_tag, lseq,
                 it.timestamp, '0, '0, '0);
        return;
      end
    end
    if (!top_ok || hold_cnt == 0) begin
      top_seq = lseq;
      top_ok  = 1'b1;
      if ((rel_ok && (rel_seq + 48'd1) == lseq) || (!rel_ok && lseq == 0)) begin
        rel_seq = lseq;
        rel_ts  = it.timestamp;
        rel_ok  = 1'b1;
        add_beat(KIND_READY, it.packet_tag, lseq, it.timestamp, '0, '0, '0);
        return;
      end
      hold_seq[0] = lseq;
      hold_ts[0]  = it.timestamp;
      hold_tag[0] = it.packet_tag;
      hold_cnt    = 1;
      return;
    end
    for (pos = 0; pos < hold_cnt; pos++) begin
      if (hold_seq[pos] == lseq) begin
        add_beat(KIND_DUPLICATE, it.packet_tag, lseq, it.timestamp, '0, '0, '0);
        return;
      end
      if (hold_seq[pos] > lseq) break;
    end
    if (pos >= hold_cnt) top_seq = lseq;
    for (int unsigned k = hold_cnt; k > pos; k--) begin
      hold_seq[k] = hold_seq[k-1];
      hold_ts[k]  = hold_ts[k-1];
      hold_tag[k] = hold_tag[k-1];
    end
    hold_seq[pos] = lseq;
    hold_ts[pos]  = it.timestamp;
    hold_tag[pos] = it.packet_tag;
    hold_cnt++;
    lim = (limit_reg > HOLD_DEPTH) ? HOLD_DEPTH : limit_reg;
    if (hold_cnt >= lim || (rel_ok && hold_seq[0] == rel_seq + 48'd1)) begin
      j = run_stop(0);
      release_run(0, j);
      for (int unsigned k = 0; k + j < hold_cnt; k++) begin
        hold_seq[k] = hold_seq[k+j];
        hold_ts[k]  = hold_ts[k+j];
        hold_tag[k] = hold_tag[k+j];
      end
      hold_cnt = hold_cnt - j;
    end
  endfunction

  // Work out every beat one input causes and queue them, last flag on the final one.
  function automatic void predict_beats(in_t it);
    pending_beats.delete();
    if (it.command) predict_flush();
    else if (it.header_bad)
      add_beat(KIND_BAD_HDR, it.packet_tag, '0, '0, '0, '0, '0);
    else predict_packet(it);
    if (pending_beats.size() > 0) pending_beats[pending_beats.size()-1].last = 1'b1;
    foreach (pending_beats[k]) expected_beats.push_back(pending_beats[k]);
  endfunction

  function automatic in_t make_pkt(logic [15:0] seq, logic [31:0] ts, logic [15:0] tag);
    in_t it;
    it = '{command: 1'b0, seq_number: seq, timestamp: ts, packet_tag: tag,
           header_bad: 1'b0};
    return it;
  endfunction

  // Flush fields other than command carry random junk on purpose.
  function automatic in_t make_flush();
    in_t it;
    it = '{command: 1'b1, seq_number: 16'($urandom), timestamp: $urandom,
           packet_tag: 16'($urandom), header_bad: 1'($urandom)};
    return it;
  endfunction

  // Present one beat, hold it until taken, then predict. Valid stays high after.
  task automatic send_item(in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_beats(it);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted beat has arrived, then let the
  // sequencer finish any store-only input.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * REG_BUFFER_LIMIT);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    limit_reg = value & 63;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_directed();
    // First packet ever at sequence zero leaves at once.
    send_item(make_pkt(16'd0, 32'd0, 16'h0000));
    // Bad header with all ones in every field.
    send_item('{command: 1'b0, seq_number: 16'hFFFF, timestamp: 32'hFFFF_FFFF,
                packet_tag: 16'hFFFF, header_bad: 1'b1});
    // Straggler from before a wrap that never happened: late.
    send_item(make_pkt(16'd65100, 32'hFFFF_FFFF, 16'h0001));
    // Out of order pair, then duplicate and late copies.
    send_item(make_pkt(16'd2, 32'd320, 16'h0002));
    send_item(make_pkt(16'd1, 32'd160, 16'h0003));
    send_item(make_pkt(16'd2, 32'd320, 16'h0004));
    send_item(make_pkt(16'd1, 32'd160, 16'h0005));
    // Duplicate of a held entry, then a flush releasing with an erasure.
    send_item(make_pkt(16'd5, 32'd800, 16'h0006));
    send_item(make_pkt(16'd4, 32'd640, 16'h0007));
    send_item(make_pkt(16'd5, 32'd800, 16'h0008));
    send_item(make_flush());
    // Flush with nothing held.
    send_item(make_flush());
    // Several runs held: the earlier ones drop, the last one goes out.
    send_item(make_pkt(16'd10, 32'd1600, 16'hFFFF));
    send_item(make_pkt(16'd12, 32'd1920, 16'h0009));
    send_item(make_pkt(16'd15, 32'h0000_0000, 16'h000A));
    send_item(make_flush());
    drain();
    // Smallest limit: every insert into a non-empty buffer forces a release.
    write_limit(1);
    send_item(make_pkt(16'd20, 32'd3200, 16'h000B));
    send_item(make_pkt(16'd30, 32'd9600, 16'h000C));
    send_item(make_pkt(16'd40, 32'h8000_0000, 16'h000D));
    send_item(make_flush());
    drain();
    write_limit(LIMIT_RESET);
  endtask

  // Mostly well-formed, slightly reordered traffic with gaps; some noise.
  task automatic test_random_phase(int unsigned limit, int unsigned count);
    in_t         it;
    int unsigned r;
    int          offs;
    write_limit(limit);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        it = make_pkt(16'($urandom), $urandom, 16'($urandom));
        it.header_bad = 1'b1;
      end else if (r < 10) it = make_flush();
      else if (r < 12) it = make_pkt(16'($urandom), $urandom, 16'($urandom));
      else begin
        offs = int'($urandom_range(0, 7)) - 2;
        it = make_pkt(gen_seq + 16'(offs), gen_ts + 32'(offs * 160), 16'($urandom));
        if ($urandom_range(0, 19) == 0) it.timestamp = $urandom;
        gen_seq = gen_seq + 16'($urandom_range(0, 2));
        gen_ts  = gen_ts + 32'd240;
      end
      send_item(it);
    end
    drain();
  endtask

  // Receiver stalls in bursts; checker compares each beat with the oldest prediction.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) begin
      beats_seen <= beats_seen + 1;
      if (expected_beats.size() == 0) begin
        fails <= fails + 1;
        if (mismatches < 10) $display("unexpected beat %p", out_data_o);
        mismatches <= mismatches + 1;
      end else begin
        automatic out_t e = expected_beats.pop_front();
        if (e.kind == KIND_ERASURE) erasures_seen <= erasures_seen + 1;
        if (out_data_o.kind !== e.kind || out_data_o.out_tag !== e.out_tag ||
            out_data_o.logical_seq !== e.logical_seq ||
            out_data_o.out_timestamp !== e.out_timestamp ||
            out_data_o.gap_start !== e.gap_start || out_data_o.gap_end !== e.gap_end ||
            out_data_o.gap_ts_step !== e.gap_ts_step || out_data_o.last !== e.last) begin
          fails <= fails + 1;
          if (mismatches < 10) $display("mismatch: expected %p actual %p", e, out_data_o);
          mismatches <= mismatches + 1;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else if (!quiet && rst_ni && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(1, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d beats outstanding", expected_beats.size());
      $display("rtp_jitter_reorder_buffer test failed");
      $finish;
    end
  end

  initial begin
    hold_cnt = 0; wraps = '0; rel_seq = '0; rel_ts = '0; top_seq = '0;
    rel_ok = 1'b0; top_ok = 1'b0; limit_reg = LIMIT_RESET;
    fails = 0; mismatches = 0; items_sent = 0; beats_seen = 0;
    erasures_seen = 0; cycles = 0; stall_left = 0; quiet = 1'b0;
    gen_seq = 16'd65400; gen_ts = 32'hFFFF_0000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(32, 50);
    test_random_phase(4, 45);
    test_random_phase(1, 40);
    test_random_phase(16, 45);
    quiet = 1'b1;
    test_random_phase(32, 50);
    if (expected_beats.size() != 0) fails = fails + expected_beats.size();
    $display("sent %0d input beats over limits 1..32, checked %0d result beats",
             items_sent, beats_seen);
    $display("including %0d erasures, sequence wrap at 16 bits, flushes and drops",
             erasures_seen);
    if (fails == 0) begin
      $display("rtp_jitter_reorder_buffer test passed");
    end else begin
      $display("%0d failures", fails);
      $display("rtp_jitter_reorder_buffer test failed");
    end
    $finish;
  end

endmodule

@@ rtp_jitter_reorder_buffer.f @@
+incdir+hdl
hdl/rtp_jrb_pkg.sv
hdl/rtp_jrb_buf.sv
hdl/rtp_jrb_div.sv
hdl/rtp_jitter_reorder_buffer.sv
test/tb_top.sv
